// ===== rtl/kvct_pkg.sv =====
// kvct_pkg: shared types, constants and key helpers for the key/value cell table.
// Used by kvct_cell and key_value_cell_table_core. Has no dependencies of its own.
package kvct_pkg;

    // Width in bits of a stored value size, which counts bytes
    localparam int SIZE_W   = 4;
    // Most keys one list request may return
    localparam int LIST_CAP = 32;

    typedef enum logic [1:0] {
        MD_WRITE  = 2'd0,
        MD_READ   = 2'd1,
        MD_DELETE = 2'd2,
        MD_LIST   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_KEY   = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SMALL_BUF = 3'd4
    } t_status;

    // Count the bytes before the first zero byte (8 when there is none)
    function automatic logic [3:0] key_len(input logic [63:0] k);
        logic [3:0] n;
        logic       stop;
        n    = 4'd0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!stop && k[8*b +: 8] != 8'd0) begin
                n = n + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    // Mask covering the low n bytes
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/kvct_cell.sv =====
// kvct_cell: one table entry (used flag, key, value, size) in the rotating chain.
// Takes its next contents from its neighbour on each shift. Uses kvct_pkg.
module kvct_cell #(
    parameter int KW = 56,
    parameter int VW = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic                         i_used,
    input  logic [KW-1:0]                i_key,
    input  logic [VW-1:0]                i_value,
    input  logic [kvct_pkg::SIZE_W-1:0]  i_size,
    output logic                         o_used,
    output logic [KW-1:0]                o_key,
    output logic [VW-1:0]                o_value,
    output logic [kvct_pkg::SIZE_W-1:0]  o_size
);

    logic                        r_used;
    logic [KW-1:0]               r_key;
    logic [VW-1:0]               r_value;
    logic [kvct_pkg::SIZE_W-1:0] r_size;

    // Advance the entry along the chain; the table is empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_key  <= '0;
            r_size <= '0;
        end else if (i_shift) begin
            r_used <= i_used;
            r_key  <= i_key;
            r_size <= i_size;
        end
    end

    // Value bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_value;
        end
    end

    assign o_used  = r_used;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_size  = r_size;

endmodule

// ===== rtl/key_value_cell_table_core.sv =====
// key_value_cell_table_core: key/value table built as a ring of kvct_cell entries.
// Requests rotate the ring past a single head unit. Uses kvct_pkg, kvct_cell.
//
//   channel | direction | handshake        | fields
//   --------+-----------+------------------+---------------------------------------------
//   request | in        | i_valid/o_stall  | mode key value val_len buf_room key_limit
//   result  | out       | o_valid/i_stall  | status read_value size_out key_out has_key
//           |           |                  | list_count entries_used last
//
// A request makes one pass of the ring past the head, then gives the result beat.
// A write of a new key takes a second pass to claim the free cell.
// A write with a bad key or size skips the pass. A list pauses the ring while its
// result beats are stalled. Reset is synchronous and empties the table at once.
// One request is in work at a time; o_stall is high until its last beat is registered.
module key_value_cell_table_core #(
    parameter int ENTRIES     = 32,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    input  logic [3:0]  i_val_len,
    input  logic [3:0]  i_buf_room,
    input  logic [5:0]  i_key_limit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_value,
    output logic [3:0]  o_size_out,
    output logic [63:0] o_key_out,
    output logic        o_has_key,
    output logic [5:0]  o_list_count,
    output logic [5:0]  o_entries_used,
    output logic        o_last
);

    localparam int KW = (KEY_BYTES - 1) * 8;
    localparam int VW = VALUE_BYTES * 8;
    localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = kvct_pkg::SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM,
        S_FIN
    } t_state;

    t_state            r_state;
    kvct_pkg::t_mode   r_mode;
    logic [63:0]       r_nk;
    logic [63:0]       r_pm;
    logic              r_keyok;
    logic [VW-1:0]     r_val;
    logic [SW-1:0]     r_vsize;
    logic [3:0]        r_bsize;
    logic [5:0]        r_cap;
    logic [5:0]        r_cnt;
    logic [PW-1:0]     r_pos;
    logic              r_found;
    logic              r_free_found;
    logic [PW-1:0]     r_free_idx;
    logic [CW-1:0]     r_used;
    kvct_pkg::t_status r_res_status;
    logic [63:0]       r_res_val;
    logic [SW-1:0]     r_res_size;
    logic              r_pend;
    logic [63:0]       r_pend_key;
    logic [5:0]        r_pend_cnt;

    logic              r_ov;
    logic [2:0]        r_o_status;
    logic [63:0]       r_o_rval;
    logic [3:0]        r_o_size;
    logic [63:0]       r_o_key;
    logic              r_o_has;
    logic [5:0]        r_o_cnt;
    logic [5:0]        r_o_used;
    logic              r_o_last;

    // Ring of cells
    logic              c_used  [ENTRIES];
    logic [KW-1:0]     c_key   [ENTRIES];
    logic [VW-1:0]     c_value [ENTRIES];
    logic [SW-1:0]     c_size  [ENTRIES];

    logic              n_used;
    logic [KW-1:0]     n_key;
    logic [VW-1:0]     n_value;
    logic [SW-1:0]     n_size;

    logic              w_shift;
    logic              w_hold;
    logic              w_end;
    logic              w_hit_eq;
    logic              w_hit_pfx;
    logic              w_take;
    logic              w_found;
    logic              w_free_found;
    logic [PW-1:0]     w_free_idx;
    logic              w_o_free;
    logic              w_list_push;
    logic              w_fin_load;
    logic              w_bad_key;
    logic              w_bad_size;
    logic [63:0]       w_head_key;
    logic [63:0]       w_head_val;
    logic [3:0]        w_len;
    logic [63:0]       w_in_mask;
    logic [6:0]        w_used_wide;
    logic [ENTRIES-1:0] w_used_vec;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic          l_used;
            logic [KW-1:0] l_key;
            logic [VW-1:0] l_value;
            logic [SW-1:0] l_size;

            if (gi == ENTRIES - 1) begin : g_tail
                assign l_used  = n_used;
                assign l_key   = n_key;
                assign l_value = n_value;
                assign l_size  = n_size;
            end else begin : g_mid
                assign l_used  = c_used[gi+1];
                assign l_key   = c_key[gi+1];
                assign l_value = c_value[gi+1];
                assign l_size  = c_size[gi+1];
            end

            kvct_cell #(
                .KW (KW),
                .VW (VW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_used  (l_used),
                .i_key   (l_key),
                .i_value (l_value),
                .i_size  (l_size),
                .o_used  (c_used[gi]),
                .o_key   (c_key[gi]),
                .o_value (c_value[gi]),
                .o_size  (c_size[gi])
            );

            assign w_used_vec[gi] = c_used[gi];
        end
    endgenerate

    // Head compare on the entry at cell zero
    assign w_head_key = 64'(c_key[0]);
    assign w_head_val = 64'(c_value[0]);
    assign w_hit_eq   = r_keyok && c_used[0] && (w_head_key == r_nk);
    assign w_hit_pfx  = r_keyok && c_used[0] && ((w_head_key & r_pm) == r_nk);
    assign w_take     = w_hit_pfx && (r_cnt < r_cap);
    assign w_o_free   = !r_ov || !i_stall;
    assign w_hold     = (r_state == S_SCAN) && (r_mode == kvct_pkg::MD_LIST)
                        && w_take && r_pend && !w_o_free;
    assign w_shift    = ((r_state == S_SCAN) || (r_state == S_CLAIM)) && !w_hold;
    assign w_end      = (r_pos == PW'(ENTRIES - 1));

    // Load the output register with a mid-list beat or the final beat
    assign w_list_push = (r_state == S_SCAN) && w_shift && (r_mode == kvct_pkg::MD_LIST)
                         && w_take && r_pend;
    assign w_fin_load  = (r_state == S_FIN) && w_o_free;

    assign w_found      = r_found || w_hit_eq;
    assign w_free_found = r_free_found || !c_used[0];
    assign w_free_idx   = r_free_found ? r_free_idx : r_pos;

    assign w_len      = kvct_pkg::key_len(i_key);
    assign w_in_mask  = kvct_pkg::byte_mask(w_len);
    assign w_bad_key  = (i_mode == kvct_pkg::MD_WRITE) && !(w_len < 4'(KEY_BYTES));
    assign w_bad_size = (i_mode == kvct_pkg::MD_WRITE) && (i_val_len > 4'(VALUE_BYTES));

    // Edit the entry leaving the head before it re-enters at the tail
    always_comb begin
        n_used  = c_used[0];
        n_key   = c_key[0];
        n_value = c_value[0];
        n_size  = c_size[0];
        if (r_state == S_SCAN && w_hit_eq && r_mode == kvct_pkg::MD_WRITE) begin
            n_value = r_val;
            n_size  = r_vsize;
        end else if (r_state == S_SCAN && w_hit_eq && r_mode == kvct_pkg::MD_DELETE) begin
            n_used  = 1'b0;
            n_key   = '0;
            n_value = '0;
            n_size  = '0;
        end else if (r_state == S_CLAIM && r_pos == r_free_idx) begin
            n_used  = 1'b1;
            n_key   = r_nk[KW-1:0];
            n_value = r_val;
            n_size  = r_vsize;
        end
    end

    // Sequencer, result capture and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_ov <= w_list_push || w_fin_load || (r_ov && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode       <= kvct_pkg::t_mode'(i_mode);
                        r_nk         <= i_key & w_in_mask;
                        r_pm         <= w_in_mask;
                        r_keyok      <= (w_len < 4'(KEY_BYTES));
                        r_val        <= VW'(i_value & kvct_pkg::byte_mask(i_val_len));
                        r_vsize      <= i_val_len;
                        r_bsize      <= i_buf_room;
                        r_cap        <= (i_key_limit > 6'(kvct_pkg::LIST_CAP))
                                        ? 6'(kvct_pkg::LIST_CAP) : i_key_limit;
                        r_cnt        <= '0;
                        r_pos        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_pend       <= 1'b0;
                        r_res_status <= w_bad_key  ? kvct_pkg::ST_BAD_KEY :
                                        w_bad_size ? kvct_pkg::ST_NO_ROOM : kvct_pkg::ST_OK;
                        r_res_val    <= '0;
                        r_res_size   <= '0;
                        if (w_bad_key || w_bad_size) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_shift) begin
                        r_pos <= w_end ? '0 : PW'(r_pos + 1'b1);
                        case (r_mode)
                            kvct_pkg::MD_WRITE: begin
                                r_found      <= w_found;
                                r_free_found <= w_free_found;
                                r_free_idx   <= w_free_idx;
                                if (w_end) begin
                                    if (w_found) begin
                                        r_state <= S_FIN;
                                    end else if (w_free_found) begin
                                        r_state <= S_CLAIM;
                                    end else begin
                                        r_res_status <= kvct_pkg::ST_NO_ROOM;
                                        r_state      <= S_FIN;
                                    end
                                end
                            end
                            kvct_pkg::MD_READ, kvct_pkg::MD_DELETE: begin
                                r_found <= w_found;
                                if (w_hit_eq && r_mode == kvct_pkg::MD_READ) begin
                                    r_res_size <= c_size[0];
                                    if (r_bsize < 4'(c_size[0])) begin
                                        r_res_status <= kvct_pkg::ST_SMALL_BUF;
                                    end else begin
                                        r_res_val <= w_head_val;
                                    end
                                end
                                if (w_hit_eq && r_mode == kvct_pkg::MD_DELETE
                                    && r_used != '0) begin
                                    r_used <= CW'(r_used - 1'b1);
                                end
                                if (w_end) begin
                                    if (!w_found) begin
                                        r_res_status <= kvct_pkg::ST_NOT_FOUND;
                                    end
                                    r_state <= S_FIN;
                                end
                            end
                            kvct_pkg::MD_LIST: begin
                                if (w_take) begin
                                    r_cnt      <= 6'(r_cnt + 1'b1);
                                    r_pend     <= 1'b1;
                                    r_pend_key <= w_head_key;
                                    r_pend_cnt <= 6'(r_cnt + 1'b1);
                                    if (r_pend) begin
                                        r_o_status <= kvct_pkg::ST_OK;
                                        r_o_rval   <= '0;
                                        r_o_size   <= '0;
                                        r_o_key    <= r_pend_key;
                                        r_o_has    <= 1'b1;
                                        r_o_cnt    <= r_pend_cnt;
                                        r_o_used   <= w_used_wide[5:0];
                                        r_o_last   <= 1'b0;
                                    end
                                end
                                if (w_end) begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_CLAIM: begin
                    r_pos <= w_end ? '0 : PW'(r_pos + 1'b1);
                    if (r_pos == r_free_idx) begin
                        r_used <= CW'(r_used + 1'b1);
                    end
                    if (w_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_o_free) begin
                        r_o_used <= w_used_wide[5:0];
                        r_o_last <= 1'b1;
                        if (r_mode == kvct_pkg::MD_LIST) begin
                            r_o_status <= kvct_pkg::ST_OK;
                            r_o_rval   <= '0;
                            r_o_size   <= '0;
                            r_o_key    <= r_pend ? r_pend_key : 64'd0;
                            r_o_has    <= r_pend;
                            r_o_cnt    <= r_pend ? r_pend_cnt : 6'd0;
                        end else begin
                            r_o_status <= r_res_status;
                            r_o_rval   <= r_res_val;
                            r_o_size   <= 4'(r_res_size);
                            r_o_key    <= '0;
                            r_o_has    <= 1'b0;
                            r_o_cnt    <= '0;
                        end
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_used_wide = 7'(r_used);

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_o_status;
    assign o_read_value   = r_o_rval;
    assign o_size_out     = r_o_size;
    assign o_key_out      = r_o_key;
    assign o_has_key      = r_o_has;
    assign o_list_count   = r_o_cnt;
    assign o_entries_used = r_o_used;
    assign o_last         = r_o_last;

    // Occupancy count agrees with the used flags between requests
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_used_vec) == int'(r_used)))
        else $error("occupancy count differs from used cells");

    // A beat that is not the last one always carries a listed key
    a_mid_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_has_key)
        else $error("non-final beat without a key");

    // A listed key always goes out with status ok
    a_key_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_key) |-> (o_status == kvct_pkg::ST_OK))
        else $error("listed key with bad status");

    // The ring only moves while a pass is in work
    a_shift_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> ((r_state == S_SCAN) || (r_state == S_CLAIM)))
        else $error("ring moved outside a pass");

endmodule

// ===== bench/tb_key_value_cell_table_core.sv =====
// Testbench for key_value_cell_table_core: writes, reads, deletes and prefix lists
// checked beat by beat against a local model of the table. Depends on kvct_pkg.
`timescale 1ns / 1ps

class kv_table_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [3:0]  size_out;
        logic [63:0] key_out;
        logic        has_key;
        logic [5:0]  list_count;
        logic [5:0]  entries_used;
        logic        last;
    } t_beat;

    bit          cell_used [32];
    logic [63:0] cell_key [32];
    logic [63:0] cell_value [32];
    logic [3:0]  cell_size [32];
    int unsigned used_total;
    t_beat       pending [$];
    int          errors;
    int          beats_seen;
    int          lists_with_keys;

    function new();
        for (int i = 0; i < 32; i++) begin
            cell_used[i] = 0; cell_key[i] = '0; cell_value[i] = '0; cell_size[i] = '0;
        end
        used_total = 0; errors = 0; beats_seen = 0; lists_with_keys = 0;
    endfunction

    static function int unsigned key_length(logic [63:0] k);
        int unsigned n;
        n = 0;
        while (n < 8 && k[8*n +: 8] != 8'd0) n++;
        return n;
    endfunction

    static function logic [63:0] low_bytes(int unsigned n);
        if (n >= 8) return '1;
        return (64'd1 << (8*n)) - 64'd1;
    endfunction

    function int locate(logic [63:0] k);
        int unsigned n;
        logic [63:0] nk;
        n = key_length(k);
        nk = k & low_bytes(n);
        if (n >= 8) return -1;
        for (int i = 0; i < 32; i++)
            if (cell_used[i] && cell_key[i] == nk) return i;
        return -1;
    endfunction

    function void push(logic [2:0] st, logic [63:0] rv, logic [3:0] sz,
                       logic [63:0] ko, logic hk, logic [5:0] lc, logic lst);
        t_beat b;
        b.status = st; b.read_value = rv; b.size_out = sz; b.key_out = ko;
        b.has_key = hk; b.list_count = lc; b.entries_used = used_total[5:0];
        b.last = lst;
        pending.push_back(b);
    endfunction

    // Note an accepted request and queue the beats it should cause
    function void note_request(logic [1:0] md, logic [63:0] k, logic [63:0] v,
                               logic [3:0] vs, logic [3:0] bs, logic [5:0] mk);
        int unsigned n, cap, cnt;
        int slot;
        logic [63:0] nk, pm;
        n = key_length(k);
        nk = k & low_bytes(n);
        case (md)
            kvct_pkg::MD_WRITE: begin
                if (n >= 8) push(kvct_pkg::ST_BAD_KEY, 0, 0, 0, 0, 0, 1);
                else if (vs > 8) push(kvct_pkg::ST_NO_ROOM, 0, 0, 0, 0, 0, 1);
                else begin
                    slot = locate(k);
                    if (slot < 0)
                        for (int i = 0; i < 32; i++)
                            if (!cell_used[i]) begin slot = i; break; end
                    if (slot < 0) push(kvct_pkg::ST_NO_ROOM, 0, 0, 0, 0, 0, 1);
                    else begin
                        if (!cell_used[slot]) begin
                            cell_used[slot] = 1; cell_key[slot] = nk; used_total++;
                        end
                        cell_value[slot] = v & low_bytes(vs);
                        cell_size[slot] = vs;
                        push(kvct_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                    end
                end
            end
            kvct_pkg::MD_READ: begin
                slot = locate(k);
                if (slot < 0) push(kvct_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
                else if (bs < cell_size[slot])
                    push(kvct_pkg::ST_SMALL_BUF, 0, cell_size[slot], 0, 0, 0, 1);
                else push(kvct_pkg::ST_OK, cell_value[slot] & low_bytes(cell_size[slot]),
                          cell_size[slot], 0, 0, 0, 1);
            end
            kvct_pkg::MD_DELETE: begin
                slot = locate(k);
                if (slot < 0) push(kvct_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
                else begin
                    cell_used[slot] = 0; cell_key[slot] = 0;
                    cell_value[slot] = 0; cell_size[slot] = 0;
                    if (used_total > 0) used_total--;
                    push(kvct_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                end
            end
            default: begin
                pm = low_bytes(n);
                cap = (mk < 32) ? mk : 32;
                cnt = 0;
                if (n < 8)
                    for (int i = 0; i < 32 && cnt < cap; i++)
                        if (cell_used[i] && (cell_key[i] & pm) == nk) begin
                            cnt++;
                            push(kvct_pkg::ST_OK, 0, 0, cell_key[i], 1, cnt[5:0], 0);
                        end
                if (cnt == 0) push(kvct_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                else begin
                    pending[pending.size()-1].last = 1;
                    lists_with_keys++;
                end
            end
        endcase
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_beat(t_beat got);
        t_beat exp_b;
        beats_seen++;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %h", $realtime, got);
            return;
        end
        exp_b = pending.pop_front();
        if (got.status !== exp_b.status) begin errors++;
            $display("%0t: status exp %0d got %0d", $realtime, exp_b.status, got.status); end
        if (got.read_value !== exp_b.read_value) begin errors++;
            $display("%0t: read_value exp %h got %h", $realtime, exp_b.read_value,
                     got.read_value); end
        if (got.size_out !== exp_b.size_out) begin errors++;
            $display("%0t: size_out exp %0d got %0d", $realtime, exp_b.size_out,
                     got.size_out); end
        if (got.key_out !== exp_b.key_out) begin errors++;
            $display("%0t: key_out exp %h got %h", $realtime, exp_b.key_out, got.key_out); end
        if (got.has_key !== exp_b.has_key) begin errors++;
            $display("%0t: has_key exp %b got %b", $realtime, exp_b.has_key, got.has_key); end
        if (got.list_count !== exp_b.list_count) begin errors++;
            $display("%0t: list_count exp %0d got %0d", $realtime, exp_b.list_count,
                     got.list_count); end
        if (got.entries_used !== exp_b.entries_used) begin errors++;
            $display("%0t: entries_used exp %0d got %0d", $realtime, exp_b.entries_used,
                     got.entries_used); end
        if (got.last !== exp_b.last) begin errors++;
            $display("%0t: last exp %b got %b", $realtime, exp_b.last, got.last); end
    endfunction
endclass

module tb_key_value_cell_table_core;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = '0;
    logic [63:0] i_key = '0;
    logic [63:0] i_value = '0;
    logic [3:0]  i_val_len = '0;
    logic [3:0]  i_buf_room = '0;
    logic [5:0]  i_key_limit = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [63:0] o_read_value;
    logic [3:0]  o_size_out;
    logic [63:0] o_key_out;
    logic        o_has_key;
    logic [5:0]  o_list_count;
    logic [5:0]  o_entries_used;
    logic        o_last;

    kv_table_scoreboard table_model = new();
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 0;
    longint      cycle_count = 0;
    int          requests_sent = 0;
    logic [63:0] key_pool [8];

    key_value_cell_table_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort on a run that never settles
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("tb_key_value_cell_table_core failed");
            $finish;
        end
    end

    // Result side: stall at random, or hold off entirely; check each beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            table_model.check_beat({o_status, o_read_value, o_size_out, o_key_out,
                                    o_has_key, o_list_count, o_entries_used, o_last});
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Offer one request beat and hold it until accepted
    task automatic send_request(logic [1:0] md, logic [63:0] k, logic [63:0] v,
                                logic [3:0] vs, logic [3:0] bs, logic [5:0] mk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= md; i_key <= k; i_value <= v;
        i_val_len <= vs; i_buf_room <= bs; i_key_limit <= mk;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        table_model.note_request(md, k, v, vs, bs, mk);
        requests_sent++;
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int unsigned n;
        k = {$urandom, $urandom};
        n = $urandom_range(7);
        for (int b = 0; b < 8; b++) begin
            if (b < n && k[8*b +: 8] == 0) k[8*b +: 8] = 8'h41;
            if (b >= n) k[8*b +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        end
        k[8*n +: 8] = 8'h00;
        return k;
    endfunction

    // Mostly keys from a small pool, so updates, hits and prefixes recur
    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 70) return key_pool[$urandom_range(7)];
        if (r < 75) return {$urandom | 32'h01010101, $urandom | 32'h01010101};
        return random_key();
    endfunction

    task automatic random_requests(int count);
        logic [1:0] md;
        logic [63:0] k;
        for (int i = 0; i < count; i++) begin
            md = 2'($urandom_range(3));
            k = pick_key();
            if (md == kvct_pkg::MD_LIST && $urandom_range(1)) k = k & 64'hFFFF;
            send_request(md, k, {$urandom, $urandom},
                         ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                  : 4'($urandom_range(8)),
                         4'($urandom), ($urandom_range(7) == 0) ? 6'($urandom)
                                                               : 6'($urandom_range(32)));
        end
    endtask

    // Drop valid and wait until every expected beat has been seen
    task automatic drain();
        i_valid <= 1'b0;
        while (table_model.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) key_pool[i] = random_key();
        key_pool[0] = 64'h0000_0000_0000_0041;
        key_pool[1] = 64'h0000_0000_0000_4241;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every mode, each special case
        send_request(kvct_pkg::MD_READ, 64'h41, 0, 0, 15, 0);                  // empty read
        send_request(kvct_pkg::MD_LIST, 64'h0, 0, 0, 0, 32);                   // empty list
        send_request(kvct_pkg::MD_WRITE, 64'h0102030405060708, 0, 4, 0, 0);    // no terminator
        send_request(kvct_pkg::MD_WRITE, 64'h41, '1, 9, 0, 0);                 // oversized
        send_request(kvct_pkg::MD_WRITE, 64'hFF00_0000_0000_0041, '1, 8, 0, 0); // junk after zero
        send_request(kvct_pkg::MD_WRITE, 64'h00FF_FFFF_FFFF_FFFF, '1, 15, 0, 0); // bad size
        send_request(kvct_pkg::MD_WRITE, 64'h00FF_FFFF_FFFF_FFFF, 64'h1234, 2, 0, 0);
        send_request(kvct_pkg::MD_WRITE, 64'h0, 64'hAA, 1, 0, 0);              // empty key
        send_request(kvct_pkg::MD_READ, 64'h41, 0, 0, 8, 0);
        send_request(kvct_pkg::MD_READ, 64'h41, 0, 0, 3, 0);                   // buffer too small
        send_request(kvct_pkg::MD_READ, 64'h0102030405060708, 0, 0, 15, 0);
        send_request(kvct_pkg::MD_WRITE, 64'h41, 64'h55, 0, 0, 0);             // update, size 0
        send_request(kvct_pkg::MD_READ, 64'h41, 0, 0, 0, 0);
        send_request(kvct_pkg::MD_LIST, 64'h0, 0, 0, 0, 0);                    // max zero
        send_request(kvct_pkg::MD_LIST, 64'h0, 0, 0, 0, 63);
        send_request(kvct_pkg::MD_LIST, 64'h0102030405060708, 0, 0, 0, 32);
        send_request(kvct_pkg::MD_DELETE, 64'h0102030405060708, 0, 0, 0, 0);
        send_request(kvct_pkg::MD_DELETE, 64'h0, 0, 0, 0, 0);
        send_request(kvct_pkg::MD_DELETE, 64'h0, 0, 0, 0, 0);                  // not found
        drain();
        // Fill the table, overflow it, list everything
        for (int i = 0; i < 33; i++)
            send_request(kvct_pkg::MD_WRITE, 64'h4B | (64'(i + 1) << 8),
                         {$urandom, $urandom}, 8, 0, 0);
        send_request(kvct_pkg::MD_LIST, 64'h0, 0, 0, 0, 32);
        drain();

        // Long hold-off while requests keep coming
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_request(kvct_pkg::MD_LIST, 64'h4B, 0, 0, 0, 32);
                for (int i = 0; i < 6; i++)
                    send_request(kvct_pkg::MD_DELETE, 64'h4B | (64'(i + 1) << 8), 0, 0, 0, 0);
            end
        join
        drain();

        // Random phases with different idling
        send_idle_pct = 0;  stall_pct = 0;  random_requests(43); drain();
        send_idle_pct = 46; stall_pct = 0;  random_requests(43); drain();
        send_idle_pct = 0;  stall_pct = 46; random_requests(43); drain();
        send_idle_pct = 33; stall_pct = 33; random_requests(43); drain();

        $display("Sent %0d requests, checked %0d result beats, %0d lists returned keys.",
                 requests_sent, table_model.beats_seen, table_model.lists_with_keys);
        if (table_model.errors == 0 && table_model.pending.size() == 0) begin
            $display("tb_key_value_cell_table_core passed");
        end else begin
            $display("tb_key_value_cell_table_core failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/kvct_pkg.sv
rtl/kvct_cell.sv
rtl/key_value_cell_table_core.sv
bench/tb_key_value_cell_table_core.sv
